### sv/vpu_pkg.sv
// Shared types and constants for the Verlet particle update block.
// Used by the channel interfaces, the controller, the datapath and the top level.
package vpu_pkg;

  // Field and register widths
  localparam int COORD_W    = 32;
  localparam int ENERGY_W   = 47;
  localparam int SCALE_W    = 22;
  localparam int DT_W       = 21;
  localparam int LEN_W      = 31;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_LENGTH     = 2'd2;

  // Register reset values
  localparam logic [SCALE_W-1:0] SCALE_RST = 22'd1048576;
  localparam logic [DT_W-1:0]    DT_RST    = 21'd5243;
  localparam logic [LEN_W-1:0]   LEN_RST   = 31'd10485760;

  // Saturation limits
  localparam longint S32_MAX_L = 64'sd2147483647;
  localparam longint S32_MIN_L = -64'sd2147483648;
  localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};

  // Input item
  typedef struct packed {
    logic signed [COORD_W-1:0] position;
    logic signed [COORD_W-1:0] unwrapped_position;
    logic signed [COORD_W-1:0] velocity;
    logic signed [COORD_W-1:0] force_req;
    logic                      update_unwrapped;
    logic                      last_of_set;
  } vpu_in_t;

  // Result item
  typedef struct packed {
    logic signed [COORD_W-1:0] new_position;
    logic signed [COORD_W-1:0] new_unwrapped;
    logic signed [COORD_W-1:0] new_velocity;
    logic [ENERGY_W-1:0]       kinetic_energy;
    logic                      set_done;
  } vpu_out_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_NORM,
    ST_MUL2,
    ST_ADD,
    ST_WRAP,
    ST_EMIT
  } vpu_state_t;

  // Controller to datapath step commands
  typedef struct packed {
    logic capture;
    logic mul1;
    logic norm;
    logic mul2;
    logic add;
    logic wrap;
    logic emit;
  } vpu_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
  } vpu_stat_t;

endpackage

### sv/vpu_in_if.sv
// Input channel: valid/ready handshake carrying one particle component item.
// Depends on vpu_pkg for the payload type.
interface vpu_in_if import vpu_pkg::*; ();
  logic    valid;
  logic    ready;
  vpu_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### sv/vpu_out_if.sv
// Result channel: valid/ready handshake carrying one updated component item.
// Depends on vpu_pkg for the payload type.
interface vpu_out_if import vpu_pkg::*; ();
  logic     valid;
  logic     ready;
  vpu_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### sv/vpu_ctrl.sv
// Sequencer for the particle update: steps one item through the datapath.
// Depends on vpu_pkg for the state, command and status types.
module vpu_ctrl import vpu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  vpu_stat_t stat,
  output vpu_cmd_t  cmd
);

  vpu_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and step commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = ST_NORM;
      end
      ST_NORM: begin
        cmd.norm  = 1'b1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = ST_WRAP;
      end
      ST_WRAP: begin
        cmd.wrap  = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        // hold until the output register can take the item
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### sv/vpu_datapath.sv
// Datapath for the particle update: multipliers, normalize, wrap, energy sum,
// configuration registers and the output register. Depends on vpu_pkg.
module vpu_datapath import vpu_pkg::*; #(
  parameter int FRAC_BITS = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  vpu_in_t               in_data,
  input  vpu_cmd_t              cmd,
  output vpu_stat_t             stat,
  output vpu_out_t              out_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Product and intermediate widths
  localparam int PV_W  = COORD_W + SCALE_W + 1;
  localparam int PF_W  = COORD_W + DT_W + 1;
  localparam int SUM_W = PV_W + 1;
  localparam int NSW   = (SUM_W - FRAC_BITS > COORD_W + 1) ? SUM_W - FRAC_BITS : COORD_W + 1;
  localparam int PD_W  = COORD_W + DT_W + 1;
  localparam int DW    = PD_W - FRAC_BITS;
  localparam int WW    = ((DW > COORD_W) ? DW : COORD_W) + 2;
  localparam int SQ_W  = 2 * COORD_W - 1;
  localparam int TW    = SQ_W - FRAC_BITS - 1;
  localparam int EW    = ((TW > ENERGY_W) ? TW : ENERGY_W) + 1;

  localparam logic signed [NSW-1:0] NV_MAX = NSW'(S32_MAX_L);
  localparam logic signed [NSW-1:0] NV_MIN = NSW'(S32_MIN_L);
  localparam logic signed [WW-1:0]  W_MAX  = WW'(S32_MAX_L);
  localparam logic signed [WW-1:0]  W_MIN  = WW'(S32_MIN_L);

  function automatic logic signed [COORD_W-1:0] sat_n(input logic signed [NSW-1:0] x);
    logic signed [COORD_W-1:0] r;
    if (x > NV_MAX) r = COORD_W'(S32_MAX_L);
    else if (x < NV_MIN) r = COORD_W'(S32_MIN_L);
    else r = x[COORD_W-1:0];
    return r;
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_w(input logic signed [WW-1:0] x);
    logic signed [COORD_W-1:0] r;
    if (x > W_MAX) r = COORD_W'(S32_MAX_L);
    else if (x < W_MIN) r = COORD_W'(S32_MIN_L);
    else r = x[COORD_W-1:0];
    return r;
  endfunction

  // Configuration registers
  logic [SCALE_W-1:0] scale_r;
  logic [DT_W-1:0]    dt_r;
  logic [LEN_W-1:0]   len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RST;
      dt_r    <= DT_RST;
      len_r   <= LEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VELOCITY_SCALE: scale_r <= cfg_data[SCALE_W-1:0];
        CFG_TIME_STEP:      dt_r    <= cfg_data[DT_W-1:0];
        CFG_BOX_LENGTH:     len_r   <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Captured item
  logic signed [COORD_W-1:0] pos_r, unw_r, vel_r, frc_r;
  logic                      upd_r, last_r;

  // Stage registers
  logic signed [PV_W-1:0]    pv_r;
  logic signed [PF_W-1:0]    pf_r;
  logic signed [COORD_W-1:0] nv_r;
  logic signed [PD_W-1:0]    pd_r;
  logic [SQ_W-1:0]           sq_r;
  logic signed [WW-1:0]      s_r;
  logic signed [COORD_W-1:0] u_r;
  logic [TW-1:0]             term_r;
  logic signed [WW-1:0]      t_r;

  // Combinational step values
  logic signed [SUM_W-1:0]   sum_w;
  logic signed [NSW-1:0]     nvw;
  logic [COORD_W-1:0]        mag;
  logic [SQ_W-1:0]           mag_x;
  logic signed [WW-1:0]      disp;
  logic signed [WW-1:0]      uw;
  logic signed [WW-1:0]      len_x;
  logic signed [WW-1:0]      pw;
  logic [EW-1:0]             tot;
  logic [ENERGY_W-1:0]       e_new;

  logic [ENERGY_W-1:0]       energy_r;
  vpu_out_t                  out_r;
  logic                      out_valid_r;

  always_comb begin
    sum_w = SUM_W'(pv_r) + SUM_W'(pf_r);
    nvw   = NSW'(sum_w >>> FRAC_BITS);
    mag   = nv_r[COORD_W-1] ? COORD_W'(-nv_r) : COORD_W'(nv_r);
    mag_x = SQ_W'(mag);
    disp  = WW'(pd_r >>> FRAC_BITS);
    uw    = WW'(unw_r) + disp;
    len_x = $signed(WW'(len_r));
    pw    = (t_r < 0) ? t_r + len_x : t_r;
    tot   = EW'(energy_r) + EW'(term_r);
    e_new = (tot >= EW'(ENERGY_MAX)) ? ENERGY_MAX : tot[ENERGY_W-1:0];
  end

  // Item steps
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pos_r  <= in_data.position;
      unw_r  <= in_data.unwrapped_position;
      vel_r  <= in_data.velocity;
      frc_r  <= in_data.force_req;
      upd_r  <= in_data.update_unwrapped;
      last_r <= in_data.last_of_set;
    end
    // velocity times scale, force times step
    if (cmd.mul1) begin
      pv_r <= vel_r * $signed({1'b0, scale_r});
      pf_r <= frc_r * $signed({1'b0, dt_r});
    end
    // floor shift and clamp of the new velocity
    if (cmd.norm) begin
      nv_r <= sat_n(nvw);
    end
    // displacement product and squared speed
    if (cmd.mul2) begin
      pd_r <= nv_r * $signed({1'b0, dt_r});
      sq_r <= mag_x * mag_x;
    end
    // advance the position and, when selected, the unwrapped coordinate; halve and scale the energy term
    if (cmd.add) begin
      s_r    <= WW'(pos_r) + disp;
      u_r    <= upd_r ? sat_w(uw) : unw_r;
      term_r <= TW'(sq_r >> (FRAC_BITS + 1));
    end
    // upper side of the box
    if (cmd.wrap) begin
      t_r <= (s_r > len_x) ? s_r - len_x : s_r;
    end
    // lower side of the box, load the result
    if (cmd.emit) begin
      out_r.new_position   <= sat_w(pw);
      out_r.new_unwrapped  <= u_r;
      out_r.new_velocity   <= nv_r;
      out_r.kinetic_energy <= e_new;
      out_r.set_done       <= last_r;
    end
  end

  // Running energy and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      energy_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.emit) begin
        energy_r <= last_r ? '0 : e_new;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_data      = out_r;
  assign out_valid     = out_valid_r;
  assign stat.out_free = !out_valid_r || out_ready;

endmodule

### sv/verlet_particle_update.sv
// Velocity-Verlet update of one particle axis component per item.
// Each accepted item passes through the multiply, normalize, multiply, add, wrap and emit steps
// into the output register; the sequencer steps the shared datapath and takes a new item only when idle;
// a stalled output holds the sequencer in its last step until the register frees.
// Reset (rst_n, synchronous, active low) restores the registers and clears the energy sum.
module verlet_particle_update import vpu_pkg::*; #(
  parameter int FRAC_BITS = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  vpu_in_if.sink                in_ch,
  vpu_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  vpu_cmd_t  cmd;
  vpu_stat_t stat;

  // Sequencer
  vpu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Arithmetic and result register
  vpu_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_ch.data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_ch.data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

### tb/verlet_update_checker.sv
// Result checker for verlet_particle_update: follows register writes, predicts each update
// from the accepted input items and compares the result items field by field.
// Depends on vpu_pkg and on the vpu_in_if / vpu_out_if channel interfaces.
module verlet_update_checker import vpu_pkg::*; #(
  parameter int FRAC_BITS = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  vpu_in_if                     in_mon,
  vpu_out_if                    out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatch_count,
  output int                    pending_updates
);

  // Shadow copies of the registers and the running energy
  logic [SCALE_W-1:0]  scale_reg;
  logic [DT_W-1:0]     step_reg;
  logic [LEN_W-1:0]    box_reg;
  logic [ENERGY_W-1:0] energy_model;
  vpu_out_t            expected_updates[$];
  int                  errs_seen = 0;

  function automatic longint clamp32(longint x);
    if (x > S32_MAX_L) return S32_MAX_L;
    if (x < S32_MIN_L) return S32_MIN_L;
    return x;
  endfunction

  // One integration step for one component; advances the energy sum
  function automatic vpu_out_t advance_component(vpu_in_t it);
    longint   scale_l, dt_l, len_l, nv, disp, np, nu, mag, term, e;
    vpu_out_t r;
    scale_l = longint'(scale_reg);
    dt_l    = longint'(step_reg);
    len_l   = longint'(box_reg);
    // arithmetic shift of a signed value rounds toward minus infinity
    nv   = clamp32((longint'(it.velocity) * scale_l + longint'(it.force_req) * dt_l) >>> FRAC_BITS);
    disp = (nv * dt_l) >>> FRAC_BITS;
    // single wrap into the box, then saturate
    np = longint'(it.position) + disp;
    if (np > len_l) np = np - len_l;
    if (np < 0) np = np + len_l;
    np = clamp32(np);
    nu = it.update_unwrapped ? clamp32(longint'(it.unwrapped_position) + disp)
                             : longint'(it.unwrapped_position);
    // half of the squared velocity, saturating accumulation
    mag  = (nv < 0) ? -nv : nv;
    term = (mag * mag) >> (FRAC_BITS + 1);
    e    = longint'(energy_model);
    if (term >= longint'(ENERGY_MAX) - e) e = longint'(ENERGY_MAX);
    else e = e + term;
    energy_model = e[ENERGY_W-1:0];
    r.new_position   = np[COORD_W-1:0];
    r.new_unwrapped  = nu[COORD_W-1:0];
    r.new_velocity   = nv[COORD_W-1:0];
    r.kinetic_energy = energy_model;
    r.set_done       = it.last_of_set;
    if (it.last_of_set) energy_model = '0;
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    vpu_out_t got, want;
    if (!rst_n) begin
      scale_reg    = SCALE_RST;
      step_reg     = DT_RST;
      box_reg      = LEN_RST;
      energy_model = '0;
      expected_updates.delete();
    end else begin
      // register writes; unknown indexes are dropped
      if (cfg_we) begin
        case (cfg_index)
          CFG_VELOCITY_SCALE: scale_reg = cfg_data[SCALE_W-1:0];
          CFG_TIME_STEP:      step_reg  = cfg_data[DT_W-1:0];
          CFG_BOX_LENGTH:     box_reg   = cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_updates = {expected_updates, advance_component(in_mon.data)};
      end
      // compare the result item with the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.data;
        if (expected_updates.size() == 0) begin
          $error("result item with no update pending: position %0d velocity %0d",
                 got.new_position, got.new_velocity);
          errs_seen++;
        end else begin
          want = expected_updates.pop_front();
          if (got.new_position !== want.new_position) begin
            $error("new_position: expected %0d, actual %0d", want.new_position, got.new_position);
            errs_seen++;
          end
          if (got.new_unwrapped !== want.new_unwrapped) begin
            $error("new_unwrapped: expected %0d, actual %0d", want.new_unwrapped,
                   got.new_unwrapped);
            errs_seen++;
          end
          if (got.new_velocity !== want.new_velocity) begin
            $error("new_velocity: expected %0d, actual %0d", want.new_velocity, got.new_velocity);
            errs_seen++;
          end
          if (got.kinetic_energy !== want.kinetic_energy) begin
            $error("kinetic_energy: expected %0d, actual %0d", want.kinetic_energy,
                   got.kinetic_energy);
            errs_seen++;
          end
          if (got.set_done !== want.set_done) begin
            $error("set_done: expected %0d, actual %0d", want.set_done, got.set_done);
            errs_seen++;
          end
        end
      end
    end
    pending_updates <= expected_updates.size();
    mismatch_count  <= errs_seen;
  end

endmodule

### tb/tb_verlet_particle_update.sv
// Testbench top for verlet_particle_update: clock, reset, register settings, input items
// with random gaps and a result sink with random stalls; verdict from verlet_update_checker.
// Depends on vpu_pkg, vpu_in_if, vpu_out_if, the block and the checker.
module tb_verlet_particle_update;
  import vpu_pkg::*;

  localparam int               CYCLE_LIMIT = 400000;
  localparam int               HOLD_CYCLES = 300;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
  localparam logic [31:0]      ONE   = 32'h0010_0000;
  localparam logic [31:0]      S_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0]      S_MIN = 32'h8000_0000;
  localparam logic [31:0]      BOX0  = 32'(LEN_RST);

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatch_count;
  int                    pending_updates;
  int                    cycle_cnt;
  bit                    hold_req;
  bit                    quiet_tx;
  bit                    quiet_rx;
  logic [LEN_W-1:0]      cur_box;
  vpu_in_t               directed_q[$];

  vpu_in_if  in_ch();
  vpu_out_if out_ch();

  verlet_particle_update #(.FRAC_BITS(20)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  verlet_update_checker #(.FRAC_BITS(20)) u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .pending_updates (pending_updates)
  );

  always #1 clk = ~clk;

  function automatic vpu_in_t mk(logic [31:0] p, logic [31:0] u, logic [31:0] v,
                                 logic [31:0] f, logic upd, logic last);
    vpu_in_t it;
    it.position           = p;
    it.unwrapped_position = u;
    it.velocity           = v;
    it.force_req          = f;
    it.update_unwrapped   = upd;
    it.last_of_set        = last;
    return it;
  endfunction

  // append one item to the directed list
  task automatic add_directed(input vpu_in_t it);
    directed_q = {directed_q, it};
  endtask

  // tame items sit inside the box with velocities and forces of random magnitude
  function automatic vpu_in_t random_component(bit tame, logic upd, logic last);
    vpu_in_t it;
    it.position           = tame ? $urandom_range(0, cur_box) : $urandom;
    it.unwrapped_position = $urandom;
    it.velocity           = tame ? ($signed($urandom) >>> $urandom_range(4, 31)) : $urandom;
    it.force_req          = tame ? ($signed($urandom) >>> $urandom_range(4, 31)) : $urandom;
    it.update_unwrapped   = upd;
    it.last_of_set        = last;
    return it;
  endfunction

  // offer one item after an optional gap; returns at the accepting edge
  task automatic send_component(input vpu_in_t it);
    int n;
    if (!quiet_tx && $urandom_range(0, 1) == 1) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_ch.data  <= it;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // particle sets of random length, with some malformed items mixed in
  task automatic run_sets(input int n_items);
    int      left, len;
    vpu_in_t it;
    left = n_items;
    while (left > 0) begin
      len = $urandom_range(1, 8);
      if (len > left) len = left;
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 4) == 0)
          it = random_component(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        else
          it = random_component(1'b1, $urandom_range(0, 3) != 0, k == len - 1);
        send_component(it);
      end
      left -= len;
    end
  endtask

  // one long set of near full-scale velocities to drive the energy into saturation
  task automatic energy_flood(input int n_items);
    vpu_in_t it;
    for (int k = 0; k < n_items; k++) begin
      it = random_component(1'b1, 1'($urandom_range(0, 1)), k == n_items - 1);
      it.velocity  = $urandom_range(0, 1) ? {1'b0, 15'h7FFF, 16'($urandom)}
                                          : {1'b1, 15'h0000, 16'($urandom)};
      it.force_req = '0;
      send_component(it);
    end
  endtask

  // wait until every predicted update has come back and the block is idle
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_updates != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [CFG_DATA_W-1:0] s, input logic [CFG_DATA_W-1:0] d,
                                input logic [CFG_DATA_W-1:0] b, input bit stray);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_VELOCITY_SCALE;
    cfg_data  <= s;
    @(posedge clk);
    cfg_index <= CFG_TIME_STEP;
    cfg_data  <= d;
    @(posedge clk);
    cfg_index <= CFG_BOX_LENGTH;
    cfg_data  <= b;
    @(posedge clk);
    if (stray) begin
      cfg_index <= CFG_UNUSED_IDX;
      cfg_data  <= CFG_DATA_W'($urandom);
      @(posedge clk);
    end
    cfg_we  <= 1'b0;
    cur_box = b[LEN_W-1:0];
    @(posedge clk);
  endtask

  task automatic random_settings();
    apply_settings(CFG_DATA_W'($urandom_range(0, 4194303)),
                   CFG_DATA_W'($urandom_range(0, 1048576)),
                   CFG_DATA_W'($urandom_range(1, 32'h7FFF_FFFF)), 1'b0);
  endtask

  // run limit
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // result sink: random stalls, a long hold on request
  initial begin : result_sink
    int n;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (quiet_rx || $urandom_range(0, 2) != 0) begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  // stimulus
  initial begin
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    cfg_we      <= 1'b0;
    cfg_index   <= CFG_VELOCITY_SCALE;
    cfg_data    <= '0;
    hold_req    = 1'b0;
    quiet_tx    = 1'b0;
    quiet_rx    = 1'b0;
    cur_box     = LEN_RST;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed items under the reset settings
    add_directed(mk('0, '0, '0, '0, 1'b0, 1'b0));
    add_directed(mk(5 * ONE, 5 * ONE, ONE, ONE, 1'b1, 1'b0));
    // crossing the upper face, sitting exactly on it, crossing the lower face
    add_directed(mk(BOX0, '0, 100 * ONE, '0, 1'b1, 1'b0));
    add_directed(mk(BOX0, '0, '0, '0, 1'b0, 1'b0));
    add_directed(mk('0, '0, -100 * ONE, '0, 1'b1, 1'b0));
    add_directed(mk(32'hFFFF_FFFF, '0, '0, '0, 1'b0, 1'b0));
    add_directed(mk(BOX0 + 1, '0, '0, '0, 1'b0, 1'b0));
    // far outside: only one wrap
    add_directed(mk(S_MAX, S_MAX, '0, '0, 1'b0, 1'b0));
    add_directed(mk(S_MIN, S_MIN, '0, '0, 1'b0, 1'b0));
    // velocity saturation both ways
    add_directed(mk(S_MAX, '0, S_MAX, S_MAX, 1'b0, 1'b0));
    add_directed(mk(S_MIN, '0, S_MIN, S_MIN, 1'b0, 1'b0));
    // unwrapped saturation, and pass-through when not updated
    add_directed(mk(ONE, S_MAX, S_MAX, '0, 1'b1, 1'b0));
    add_directed(mk(ONE, S_MIN, S_MIN, '0, 1'b1, 1'b0));
    add_directed(mk(ONE, S_MIN, S_MIN, '0, 1'b0, 1'b0));
    add_directed(mk(ONE, '0, '0, S_MAX, 1'b1, 1'b0));
    add_directed(mk(ONE, '0, '0, S_MIN, 1'b1, 1'b1));
    add_directed(mk(2 * ONE, '0, 32'd1, '0, 1'b1, 1'b0));
    add_directed(mk(2 * ONE, '0, 32'hFFFF_FFFF, '0, 1'b1, 1'b1));
    add_directed(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    1'b1, 1'b1));
    add_directed(mk(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA,
                    1'b1, 1'b1));
    foreach (directed_q[i]) send_component(directed_q[i]);
    settle();

    // largest scale and box, unit step, plus a write to the unused index
    apply_settings(31'd4194303, 31'd1048576, 31'h7FFF_FFFF, 1'b1);
    run_sets(40);
    settle();

    // zero velocity scale, unit step, smallest nonzero box
    apply_settings(31'd0, 31'd1048576, 31'd1, 1'b0);
    run_sets(30);
    settle();

    // bits above the scale and step register widths set; zero box length
    apply_settings(31'h7FC0_0000 | 31'(SCALE_RST), 31'h7FE0_0000 | 31'(DT_RST), 31'd0, 1'b0);
    run_sets(30);
    settle();

    // energy saturation, zero step
    apply_settings(31'(SCALE_RST), 31'd0, 31'(LEN_RST), 1'b0);
    energy_flood(150);
    run_sets(6);
    settle();

    // sink holds off while the source keeps offering
    random_settings();
    quiet_tx = 1'b1;
    hold_req = 1'b1;
    run_sets(60);
    quiet_tx = 1'b0;
    settle();

    random_settings();
    run_sets(30);
    settle();

    // back to back on both sides
    random_settings();
    quiet_tx = 1'b1;
    quiet_rx = 1'b1;
    run_sets(25);
    quiet_tx = 1'b0;
    quiet_rx = 1'b0;
    settle();

    random_settings();
    run_sets(35);
    settle();
    repeat (20) @(posedge clk);

    if (mismatch_count == 0 && pending_updates == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
